@@ hw/rtl/hsi_pkg.sv @@
// package: shared types, constants and tables for the hsi color classifier
package hsi_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AngW        = 26;  // q16 degrees, signed, covers +-360
  localparam int unsigned VecW        = 30;  // cordic vector width, signed
  localparam int unsigned FullQ16     = 360 * 65536;
  localparam int unsigned HalfQ16     = 180 * 65536;
  localparam int unsigned HueGuard    = 256;
  localparam int unsigned Sqrt3Q16    = 113512;
  // sum of all atan table entries, what a zero vector loses over the cordic
  localparam int unsigned AtanSumQ16  = 6545817;
  localparam int unsigned PlAddrW     = 5;

  // register byte addresses
  localparam logic [PlAddrW-1:0] RegHueLow  = 5'd0;
  localparam logic [PlAddrW-1:0] RegHueHigh = 5'd4;
  localparam logic [PlAddrW-1:0] RegSatLow  = 5'd8;
  localparam logic [PlAddrW-1:0] RegSatHigh = 5'd12;
  localparam logic [PlAddrW-1:0] RegLumLow  = 5'd16;
  localparam logic [PlAddrW-1:0] RegLumHigh = 5'd20;

  typedef struct packed {
    logic [8:0] hue_low;
    logic [8:0] hue_high;
    logic [6:0] sat_low;
    logic [6:0] sat_high;
    logic [6:0] lum_low;
    logic [6:0] lum_high;
  } hsi_cfg_t;

  // atan(2^-i) in degrees, q16
  function automatic logic [AngW-1:0] atan_q16(input logic [3:0] i);
    logic [AngW-1:0] v;
    unique case (i)
      4'd0:  v = 26'd2949120;
      4'd1:  v = 26'd1740967;
      4'd2:  v = 26'd919879;
      4'd3:  v = 26'd466945;
      4'd4:  v = 26'd234379;
      4'd5:  v = 26'd117305;
      4'd6:  v = 26'd58666;
      4'd7:  v = 26'd29335;
      4'd8:  v = 26'd14668;
      4'd9:  v = 26'd7334;
      4'd10: v = 26'd3667;
      4'd11: v = 26'd1833;
      4'd12: v = 26'd917;
      4'd13: v = 26'd458;
      4'd14: v = 26'd229;
      default: v = 26'd115;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/hsi_color_range_classifier_core.sv @@
// top level: rgb to hsi conversion pipeline with range classification
// pipeline: 20 register stages from the input transaction to the output register
// throughput: one pixel per cycle, every stage including the 16 cordic steps is registered
// the whole pipe stalls while the output holds an untaken result
// reset: clears all valid bits and loads the default bounds
module hsi_color_range_classifier_core import hsi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,  // in_range[0], hue[9:1], sat[16:10], int[23:17]
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PlAddrW-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  hsi_cfg_t cfg;
  logic     en;

  assign pready = 1'b1;

  hsi_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg_o(cfg)
  );

  // the whole pipe advances unless the output holds an untaken result
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: sums, min and max
  logic       v1_q;
  logic [7:0] r1_q, g1_q, b1_q, mn1_q;
  logic [9:0] sum1_q;
  logic       grey1_q;
  logic [7:0] ri, gi, bi, mn, mx;

  assign ri = s_axis_tdata[7:0];
  assign gi = s_axis_tdata[15:8];
  assign bi = s_axis_tdata[23:16];

  always_comb begin
    mn = ri;
    mx = ri;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q    <= ri;
      g1_q    <= gi;
      b1_q    <= bi;
      mn1_q   <= mn;
      sum1_q  <= 10'(ri) + 10'(gi) + 10'(bi);
      grey1_q <= (mx == mn);
    end
  end

  // stage 2: scaled chroma, intensity, cordic start vector
  logic                   v2_q;
  logic [16:0]            c100_2_q;
  logic [9:0]             sum2_q;
  logic [6:0]             lum2_q;
  logic                   grey2_q;
  logic signed [VecW-1:0] x2_q, y2_q;
  logic signed [AngW-1:0] z2_q;
  logic                   yz2_q;

  logic [9:0]             chroma;
  logic signed [10:0]     xd, yd;
  logic signed [VecW-1:0] xv, yv;
  logic [16:0]            sum100;
  logic [34:0]            lum_prod;

  assign chroma   = sum1_q - 10'(3 * mn1_q);
  assign xd       = $signed({3'b0, r1_q} <<< 1) - $signed({3'b0, g1_q})
                    - $signed({3'b0, b1_q});
  assign yd       = $signed({3'b0, g1_q}) - $signed({3'b0, b1_q});
  assign xv       = VecW'(xd) <<< 16;
  assign yv       = VecW'(yd) * $signed(VecW'(Sqrt3Q16));
  assign sum100   = 17'(sum1_q) * 17'd100;
  // floor(s/765) via reciprocal 2^26/765 rounded up, exact for s < 88186
  assign lum_prod = 35'(sum100) * 35'd87725;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c100_2_q <= 17'(chroma) * 17'd100;
      sum2_q   <= sum1_q;
      lum2_q   <= lum_prod[32:26];
      grey2_q  <= grey1_q | (sum1_q == 10'd0);
      yz2_q    <= (yd == 11'sd0);
      if (yd == 11'sd0) begin
        x2_q <= '0;
        y2_q <= '0;
        z2_q <= (xd > 0) ? '0 : AngW'(HalfQ16);
      end else if (xd < 0) begin
        x2_q <= -xv;
        y2_q <= -yv;
        z2_q <= AngW'(HalfQ16);
      end else begin
        x2_q <= xv;
        y2_q <= yv;
        z2_q <= '0;
      end
    end
  end

  // saturation divide: restoring, one quotient bit per cordic stage
  // quotient <= 100 needs 7 bits; the side channel carries no divider state
  // side layout: sat rem[16:7] unused here; carry in parallel regs instead
  logic [CordicSteps:0]                v_c;
  logic signed [VecW-1:0]              x_c [CordicSteps+1];
  logic signed [VecW-1:0]              y_c [CordicSteps+1];
  logic signed [AngW-1:0]              z_c [CordicSteps+1];
  logic [22:0]                         s_c [CordicSteps+1];

  // side: yz[22], grey[21], near_grey[20], lum[19:13], unused[12:0]
  assign v_c[0] = v2_q;
  assign x_c[0] = x2_q;
  assign y_c[0] = y2_q;
  assign z_c[0] = z2_q;
  assign s_c[0] = {yz2_q, grey2_q, (c100_2_q <= 17'(sum2_q)), lum2_q, 13'd0};

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    hsi_cordic_stage #(.Step(i)) u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v_c[i]), .x_i(x_c[i]), .y_i(y_c[i]), .z_i(z_c[i]), .side_i(s_c[i]),
      .valid_o(v_c[i+1]), .x_o(x_c[i+1]), .y_o(y_c[i+1]), .z_o(z_c[i+1]),
      .side_o(s_c[i+1])
    );
  end

  // divider lanes beside the cordic: 7 quotient bits, stage k makes bit 6-k
  logic [16:0] drem_q [8];
  logic [9:0]  ddiv_q [8];
  logic [6:0]  dquo_q [8];

  assign drem_q[0] = c100_2_q;
  assign ddiv_q[0] = sum2_q;
  assign dquo_q[0] = '0;

  for (genvar k = 0; k < 7; k++) begin : g_div
    logic [16:0] trial;
    logic [16:0] rq;
    logic [9:0]  dq;
    logic [6:0]  qq;
    assign trial = 17'(ddiv_q[k]) << (6 - k);
    always_ff @(posedge clk_i) begin
      if (en) begin
        dq <= ddiv_q[k];
        if (drem_q[k] >= trial) begin
          rq <= drem_q[k] - trial;
          qq <= dquo_q[k] | (7'd1 << (6 - k));
        end else begin
          rq <= drem_q[k];
          qq <= dquo_q[k];
        end
      end
    end
    assign drem_q[k+1] = rq;
    assign ddiv_q[k+1] = dq;
    assign dquo_q[k+1] = qq;
  end

  // delay quotient to line up with cordic output
  localparam int unsigned SatDly = CordicSteps - 7;
  logic [6:0] sdly_q [SatDly];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sdly_q[0] <= dquo_q[7];
      for (int j = 1; j < SatDly; j++) sdly_q[j] <= sdly_q[j-1];
    end
  end

  // stage 19: hue wrap and select
  logic                   v3_q;
  logic [8:0]             hue3_q;
  logic [6:0]             sat3_q, lum3_q;
  logic signed [AngW-1:0] zg, zw;
  logic [8:0]             hraw;
  logic                   yzf, greyf, nearf;

  assign yzf   = s_c[CordicSteps][22];
  assign greyf = s_c[CordicSteps][21];
  assign nearf = s_c[CordicSteps][20];
  // a zero vector walks down by every table entry, restore its start angle
  assign zg    = z_c[CordicSteps] + (yzf ? AngW'(AtanSumQ16) : AngW'(0))
                 + AngW'(HueGuard);

  always_comb begin
    zw = zg;
    if (zw < 0) zw = zw + $signed(AngW'(FullQ16));
    else if (zw >= $signed(AngW'(FullQ16))) zw = zw - $signed(AngW'(FullQ16));
    hraw = zw[24:16];
    if (hraw > 9'd359) hraw = 9'd359;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v_c[CordicSteps];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue3_q <= (greyf | nearf) ? 9'd0 : hraw;
      sat3_q <= greyf ? 7'd0 : sdly_q[SatDly-1];
      lum3_q <= s_c[CordicSteps][19:13];
    end
  end

  // output register: compare and present
  logic        vo_q;
  logic [23:0] do_q;
  logic        ok;

  assign ok = (hue3_q >= cfg.hue_low) && (hue3_q <= cfg.hue_high) &&
              (sat3_q >= cfg.sat_low) && (sat3_q <= cfg.sat_high) &&
              (lum3_q > cfg.lum_low) && (lum3_q < cfg.lum_high);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en) vo_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) do_q <= {lum3_q, sat3_q, hue3_q, ok};
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = do_q;

endmodule

@@ hw/rtl/hsi_regs.sv @@
// apb configuration registers holding the classification bounds
module hsi_regs import hsi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PlAddrW-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output hsi_cfg_t           cfg_o
);

  hsi_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign wr_en = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr)
        RegHueLow:  cfg_d.hue_low  = pwdata[8:0];
        RegHueHigh: cfg_d.hue_high = pwdata[8:0];
        RegSatLow:  cfg_d.sat_low  = pwdata[6:0];
        RegSatHigh: cfg_d.sat_high = pwdata[6:0];
        RegLumLow:  cfg_d.lum_low  = pwdata[6:0];
        RegLumHigh: cfg_d.lum_high = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= 9'd312;
      cfg_q.hue_high <= 9'd360;
      cfg_q.sat_low  <= 7'd17;
      cfg_q.sat_high <= 7'd100;
      cfg_q.lum_low  <= 7'd18;
      cfg_q.lum_high <= 7'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (paddr)
      RegHueLow:  prdata = {23'd0, cfg_q.hue_low};
      RegHueHigh: prdata = {23'd0, cfg_q.hue_high};
      RegSatLow:  prdata = {25'd0, cfg_q.sat_low};
      RegSatHigh: prdata = {25'd0, cfg_q.sat_high};
      RegLumLow:  prdata = {25'd0, cfg_q.lum_low};
      RegLumHigh: prdata = {25'd0, cfg_q.lum_high};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/hsi_cordic_stage.sv @@
// one registered cordic vectoring iteration with its valid bit
module hsi_cordic_stage import hsi_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [VecW-1:0] x_i,
  input  logic signed [VecW-1:0] y_i,
  input  logic signed [AngW-1:0] z_i,
  input  logic [22:0]            side_i,
  output logic                   valid_o,
  output logic signed [VecW-1:0] x_o,
  output logic signed [VecW-1:0] y_o,
  output logic signed [AngW-1:0] z_o,
  output logic [22:0]            side_o
);

  logic signed [VecW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [AngW-1:0] z_d, z_q;
  logic [22:0]            side_q;
  logic                   valid_q;
  logic [AngW-1:0]        ang;

  assign xs  = x_i >>> Step;
  assign ys  = y_i >>> Step;
  assign ang = atan_q16(4'(Step));

  // rotate toward the x axis
  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + $signed(ang);
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - $signed(ang);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule
